### src/kss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kss_pkg: shared types and constants of the drum voice
// Word layouts of both channels, item kinds, status codes and ring sizing.
// ----------------------------------------------------------------------------
package kss_pkg;

   // ring sizing (depth must be a power of two, 4 to 4096)
   localparam int RING_DEPTH = 1024;
   localparam int RING_AW    = $clog2(RING_DEPTH);
   localparam int CNT_W      = RING_AW + 1;
   localparam int LEN_W      = 11;
   localparam int CMP_W      = (LEN_W > CNT_W) ? LEN_W : CNT_W;
   localparam int SAMPLE_W   = 16;
   localparam int TICK_W     = 32;

   localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(100);

   // item kinds
   localparam logic [1:0] KIND_CLEAR = 2'd0;
   localparam logic [1:0] KIND_LOAD  = 2'd1;
   localparam logic [1:0] KIND_TICK  = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_LOAD_FULL  = 2'd1;
   localparam logic [1:0] ST_TICK_SHORT = 2'd2;

   // saturation bound for a negated average
   localparam logic signed [SAMPLE_W:0] SAT_MAX = (SAMPLE_W+1)'(32767);

   typedef struct packed {
      logic [1:0]                 kind;
      logic signed [SAMPLE_W-1:0] sample_value;
      logic                       negate;
   } req_word_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] front_sample;
      logic                       ring_full;
      logic [TICK_W-1:0]          tick_count;
      logic [1:0]                 status;
   } rsp_word_type;

endpackage

### src/kss_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kss_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module kss_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/kss_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kss_core: ring state and one-pass step logic
// Keeps the ring pointers, tick count and cached front and second samples,
// and computes each word's result in the cycle it is stepped.
// ----------------------------------------------------------------------------
module kss_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write,
   input  logic [kss_pkg::LEN_W-1:0]   csr_data,
   input  logic                        step_en,
   input  kss_pkg::req_word_type       item,
   output kss_pkg::rsp_word_type       result
);

   localparam int AW = kss_pkg::RING_AW;
   localparam int CW = kss_pkg::CNT_W;
   localparam int SW = kss_pkg::SAMPLE_W;

   logic [kss_pkg::LEN_W-1:0]  len_ff;
   logic [AW-1:0]              head_ff, head_in;
   logic [CW-1:0]              count_ff, count_in;
   logic [kss_pkg::TICK_W-1:0] ticks_ff, ticks_in;
   logic signed [SW-1:0]       front_ff, front_in;
   logic signed [SW-1:0]       second_ff, second_in;
   logic                       pending_ff, pending_in;

   logic                       wr_en;
   logic [AW-1:0]              wr_addr;
   logic signed [SW-1:0]       wr_data;
   logic                       rd_en;
   logic [AW-1:0]              rd_addr;
   logic [SW-1:0]              rd_data;

   logic signed [SW-1:0]       second_now;
   logic signed [SW:0]         sum;
   logic signed [SW:0]         avg;
   logic signed [SW:0]         signed_avg;
   logic signed [SW-1:0]       new_sample;
   logic                       full_now;
   logic                       full_after;
   logic [1:0]                 status;

   kss_ram #(
      .WIDTH (SW),
      .DEPTH (kss_pkg::RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // second sample: fresh from the ring right after a long tick, else cached
   assign second_now = pending_ff ? $signed(rd_data) : second_ff;

   // average of front and second, truncated toward zero, then sign and clamp
   assign sum        = {front_ff[SW-1], front_ff} + {second_now[SW-1], second_now};
   assign avg        = (sum + $signed({{SW{1'b0}}, sum[SW]})) >>> 1;
   assign signed_avg = item.negate ? -avg : avg;
   assign new_sample = (signed_avg > kss_pkg::SAT_MAX) ? SW'(kss_pkg::SAT_MAX)
                                                       : signed_avg[SW-1:0];

   // fullness against the length saturated to ring depth
   assign full_now   = (kss_pkg::CMP_W'(count_ff) >= kss_pkg::CMP_W'(len_ff)) ||
                       (count_ff >= CW'(kss_pkg::RING_DEPTH));
   assign full_after = (kss_pkg::CMP_W'(count_in) >= kss_pkg::CMP_W'(len_ff)) ||
                       (count_in >= CW'(kss_pkg::RING_DEPTH));

   // step logic
   always_comb begin
      head_in    = head_ff;
      count_in   = count_ff;
      ticks_in   = ticks_ff;
      front_in   = front_ff;
      second_in  = second_now;
      pending_in = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = head_ff + count_ff[AW-1:0];
      wr_data    = item.sample_value;
      rd_en      = 1'b0;
      rd_addr    = head_ff + AW'(2);
      status     = kss_pkg::ST_OK;
      if (step_en) begin
         case (item.kind)
            kss_pkg::KIND_CLEAR: begin
               head_in  = '0;
               count_in = '0;
               ticks_in = '0;
            end
            kss_pkg::KIND_LOAD: begin
               if (full_now) begin
                  status = kss_pkg::ST_LOAD_FULL;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CW'(1);
                  if (count_ff == CW'(0)) begin
                     front_in = item.sample_value;
                  end
                  if (count_ff == CW'(1)) begin
                     second_in = item.sample_value;
                  end
               end
            end
            kss_pkg::KIND_TICK: begin
               if (count_ff < CW'(2)) begin
                  status = kss_pkg::ST_TICK_SHORT;
               end else begin
                  wr_en    = 1'b1;
                  wr_data  = new_sample;
                  head_in  = head_ff + AW'(1);
                  ticks_in = ticks_ff + kss_pkg::TICK_W'(1);
                  front_in = second_now;
                  rd_en    = 1'b1;
                  // with two samples the new second is the one just written
                  if (count_ff == CW'(2)) begin
                     second_in = new_sample;
                  end else begin
                     pending_in = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // result of this step
   always_comb begin
      result.front_sample = (count_in != CW'(0)) ? front_in : '0;
      result.ring_full    = full_after;
      result.tick_count   = ticks_in;
      result.status       = status;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff     <= kss_pkg::LEN_RESET;
         head_ff    <= '0;
         count_ff   <= '0;
         ticks_ff   <= '0;
         pending_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            len_ff <= csr_data;
         end
         head_ff    <= head_in;
         count_ff   <= count_in;
         ticks_ff   <= ticks_in;
         pending_ff <= pending_in;
      end
   end

   // sample cache
   always_ff @(posedge clock) begin
      front_ff  <= front_in;
      second_ff <= second_in;
   end

endmodule

### src/karplus_strong_drum_voice.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// karplus_strong_drum_voice: Karplus-Strong drum voice on a sample ring
// Input register, one-pass step logic and result register around a
// 1024-entry ring memory.
// ----------------------------------------------------------------------------
// The voice takes one word per clock while req_stall is low and returns one
// result word per input word via the input and result registers; a stalled
// result holds back the input only once the input register also holds a
// word. Each tick reads the front and next samples from two cached registers,
// so the ring memory needs one write and one read per cycle, and the read of
// the sample after next is the only memory read in the loop. The ring memory
// is not cleared after reset; only entries already loaded or written by a tick
// are ever read. Write csr_data (ring length) only while no word is in flight.
module karplus_strong_drum_voice (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write,
   input  logic [kss_pkg::LEN_W-1:0]  csr_data,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  kss_pkg::req_word_type      req_word,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output kss_pkg::rsp_word_type      rsp_word
);

   logic                  in_valid_ff, in_valid_in;
   kss_pkg::req_word_type in_word_ff;
   logic                  out_valid_ff, out_valid_in;
   kss_pkg::rsp_word_type out_word_ff;
   kss_pkg::rsp_word_type step_result;
   logic                  advance;
   logic                  accept;

   // step when the result register is free or is being drained
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   kss_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_data  (csr_data),
      .step_en   (advance),
      .item      (in_word_ff),
      .result    (step_result)
   );

   // valid flags of both registers
   always_comb begin
      in_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      out_valid_in = advance ? 1'b1 : (rsp_stall ? out_valid_ff : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // hold payloads until replaced
   always_ff @(posedge clock) begin
      if (accept) begin
         in_word_ff <= req_word;
      end
      if (advance) begin
         out_word_ff <= step_result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

endmodule

### src/kss_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kss_checker: port-level checks of the drum voice
// Watches both channels of the top level; bound to it below.
// ----------------------------------------------------------------------------
module kss_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input kss_pkg::rsp_word_type rsp_word
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   // reset drops the result channel
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a new result follows an accepted word
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result without an accepted word");

   // an ignored load leaves the ring full
   a_load_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.status == kss_pkg::ST_LOAD_FULL) |-> rsp_word.ring_full)
      else $error("load ignored while ring not full");

endmodule

bind karplus_strong_drum_voice kss_checker u_kss_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);
